### rtl/pq_parity_erasure_engine_top_defines.svh
// assertion helpers shared by the parity engine rtl
`ifndef PQ_PARITY_ERASURE_ENGINE_TOP_DEFINES_SVH
`define PQ_PARITY_ERASURE_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define PQPE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, ignored while in reset
`define PQPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pqpe_pkg.sv
`timescale 1ns / 1ps
package pqpe_pkg;

	localparam int LANES  = 8;
	localparam int LANE_W = $clog2(LANES);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 3;

	localparam logic [7:0] GF_REDUCE = 8'h1B;
	localparam logic [7:0] GF_TOP    = 8'h80;
	localparam logic [7:0] GF_GEN    = 8'h03;

	// mode codes
	localparam logic [1:0] MODE_ENCODE = 2'd0;
	localparam logic [1:0] MODE_ONE    = 2'd1;
	localparam logic [1:0] MODE_TWO    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOST_FIRST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOST_SECOND = 2'd2;

	typedef struct packed {
		logic [7:0] data_0;
		logic [7:0] data_1;
		logic [7:0] data_2;
		logic [7:0] data_3;
		logic [7:0] data_4;
		logic [7:0] data_5;
		logic [7:0] data_6;
		logic [7:0] data_7;
		logic [7:0] p_in;
		logic [7:0] q_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] parity_p;
		logic [7:0] parity_q;
		logic [7:0] rebuilt_first;
		logic [7:0] rebuilt_second;
		logic       setup_error;
	} out_item_t;

	// per-item control carried down the pipe
	typedef struct packed {
		logic [1:0] mode;
		logic       pair_err;
	} ctl_t;

	typedef logic [LANES-1:0][7:0]         coef_tab_t;
	typedef logic [LANES*LANES-1:0][7:0]   pair_tab_t;

	function automatic logic [7:0] gf_mul(input logic [7:0] x_in, input logic [7:0] y_in);
		logic [7:0] acc;
		logic [7:0] x;
		logic [7:0] y;
		acc = '0;
		x = x_in;
		y = y_in;
		for (int i = 0; i < 8; i++) begin
			if (y[0])
				acc = acc ^ x;
			x = ((x & GF_TOP) != 8'd0) ? ({x[6:0], 1'b0} ^ GF_REDUCE) : {x[6:0], 1'b0};
			y = {1'b0, y[7:1]};
		end
		return acc;
	endfunction

	// x^254, zero for zero
	function automatic logic [7:0] gf_inv(input logic [7:0] x);
		logic [7:0] r;
		logic [7:0] base;
		r = 8'd1;
		base = x;
		for (int e = 0; e < 8; e++) begin
			if (e != 0)
				r = gf_mul(r, base);
			base = gf_mul(base, base);
		end
		return r;
	endfunction

	function automatic coef_tab_t build_coef();
		coef_tab_t t;
		logic [7:0] c;
		c = 8'd1;
		for (int u = 0; u < LANES; u++) begin
			t[u] = c;
			c = gf_mul(c, GF_GEN);
		end
		return t;
	endfunction

	localparam coef_tab_t COEF = build_coef();

	// 1 / (coef a ^ coef b), indexed by {a, b}
	function automatic pair_tab_t build_pair_inv();
		pair_tab_t t;
		for (int a = 0; a < LANES; a++) begin
			for (int b = 0; b < LANES; b++) begin
				t[a*LANES+b] = (a == b) ? 8'd0 : gf_inv(COEF[a] ^ COEF[b]);
			end
		end
		return t;
	endfunction

	localparam pair_tab_t PAIR_INV = build_pair_inv();

endpackage

### rtl/pqpe_gf_mul.sv
`timescale 1ns / 1ps
module pqpe_gf_mul (
	input  logic [7:0] a,
	input  logic [7:0] b,
	output logic [7:0] product
);
	import pqpe_pkg::*;

	// shift-and-add over the field, reducing as we go
	always_comb begin
		logic [7:0] acc;
		logic [7:0] x;
		acc = '0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				acc = acc ^ x;
			x = ((x & GF_TOP) != 8'd0) ? ({x[6:0], 1'b0} ^ GF_REDUCE) : {x[6:0], 1'b0};
		end
		product = acc;
	end

endmodule

### rtl/pq_parity_erasure_engine_top.sv
`timescale 1ns / 1ps
// p+q parity engine over gf(2^8), one byte column per transfer
// input channel: in_valid / in_stall / in_data, one column of eight data bytes plus p and q
// output channel: out_valid / out_stall / out_data, one result per column, in order
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, ready is always high;
//   index 0 mode, 1 lost_first, 2 lost_second; write only while the pipe is empty
// path: each column passes the three register stages in order (column sums, syndrome
//   multiply, rebuild multiply); out_valid is the valid bit of the last stage
// throughput: one column per cycle while the output is not stalled; the two general field
//   multipliers each own a stage
// reset (arst_n low) empties the pipe and sets mode 0, lost_first 0, lost_second 1
// receiver stall: the result is held in the output register; upstream stages keep
//   filling any empty slots, and in_stall rises only once all three stages are full
//   and the output is stalled
module pq_parity_erasure_engine_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  pqpe_pkg::in_item_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output pqpe_pkg::out_item_t                   out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pqpe_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pqpe_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import pqpe_pkg::*;

`include "pq_parity_erasure_engine_top_defines.svh"

	// configuration registers
	logic [1:0]        mode_q;
	logic [LANE_W-1:0] lost_first_q;
	logic [LANE_W-1:0] lost_second_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_ENCODE;
			lost_first_q  <= LANE_W'(0);
			lost_second_q <= LANE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:        mode_q        <= cfg_data[1:0];
				REG_LOST_FIRST:  lost_first_q  <= cfg_data[LANE_W-1:0];
				REG_LOST_SECOND: lost_second_q <= cfg_data[LANE_W-1:0];
				default:         ;
			endcase
		end
	end

	// handshake: each stage moves when it is empty or the next one moves
	logic v_s1, v_s2, v_s3;
	logic ready1, ready2, ready3;

	assign ready3   = !v_s3 || !out_stall;
	assign ready2   = !v_s2 || ready3;
	assign ready1   = !v_s1 || ready2;
	assign in_stall = !ready1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready1)
				v_s1 <= in_valid;
			if (ready2)
				v_s2 <= v_s1;
			if (ready3)
				v_s3 <= v_s2;
		end
	end

	// stage 1: fold the surviving lanes into the p and q syndromes
	logic [LANES-1:0][7:0] lane_d;
	logic [7:0]            pp_next, qq_next;
	ctl_t                  ctl_next;

	assign lane_d[0] = in_data.data_0;
	assign lane_d[1] = in_data.data_1;
	assign lane_d[2] = in_data.data_2;
	assign lane_d[3] = in_data.data_3;
	assign lane_d[4] = in_data.data_4;
	assign lane_d[5] = in_data.data_5;
	assign lane_d[6] = in_data.data_6;
	assign lane_d[7] = in_data.data_7;

	always_comb begin
		logic [7:0] p_acc;
		logic [7:0] q_acc;
		logic       lane_lost;
		p_acc = (mode_q == MODE_ENCODE) ? 8'd0 : in_data.p_in;
		q_acc = (mode_q == MODE_TWO) ? in_data.q_in : 8'd0;
		for (int u = 0; u < LANES; u++) begin
			lane_lost = ((mode_q != MODE_ENCODE) && (LANE_W'(u) == lost_first_q)) ||
				((mode_q == MODE_TWO) && (LANE_W'(u) == lost_second_q));
			if (!lane_lost) begin
				p_acc = p_acc ^ lane_d[u];
				q_acc = q_acc ^ gf_mul(COEF[u], lane_d[u]);
			end
		end
		pp_next = p_acc;
		qq_next = q_acc;
		ctl_next.mode     = mode_q;
		ctl_next.pair_err = (mode_q == MODE_TWO) && (lost_first_q == lost_second_q);
	end

	logic [7:0] pp_s1, qq_s1, cb_s1, inv_s1;
	ctl_t       ctl_s1;

	always_ff @(posedge clk) begin
		if (ready1) begin
			pp_s1  <= pp_next;
			qq_s1  <= qq_next;
			// only the double rebuild folds p into q; encode passes q through
			cb_s1  <= (mode_q == MODE_TWO) ? COEF[lost_second_q] : 8'd0;
			inv_s1 <= PAIR_INV[{lost_first_q, lost_second_q}];
			ctl_s1 <= ctl_next;
		end
	end

	// stage 2: q syndrome corrected by cb times p syndrome
	logic [7:0] cb_pp;

	pqpe_gf_mul u_mul_syn (
		.a       (cb_s1),
		.b       (pp_s1),
		.product (cb_pp)
	);

	logic [7:0] t_s2, pp_s2, inv_s2;
	ctl_t       ctl_s2;

	always_ff @(posedge clk) begin
		if (ready2) begin
			t_s2   <= qq_s1 ^ cb_pp;
			pp_s2  <= pp_s1;
			inv_s2 <= inv_s1;
			ctl_s2 <= ctl_s1;
		end
	end

	// stage 3: rebuild the first lost byte and shape the result
	logic [7:0] da;
	out_item_t  res_next;

	pqpe_gf_mul u_mul_rebuild (
		.a       (t_s2),
		.b       (inv_s2),
		.product (da)
	);

	always_comb begin
		res_next = '0;
		case (ctl_s2.mode)
			MODE_ENCODE: begin
				res_next.parity_p = pp_s2;
				res_next.parity_q = t_s2;
			end
			MODE_ONE: begin
				res_next.rebuilt_first = pp_s2;
			end
			MODE_TWO: begin
				if (ctl_s2.pair_err) begin
					res_next.setup_error = 1'b1;
				end else begin
					res_next.rebuilt_first  = da;
					res_next.rebuilt_second = pp_s2 ^ da;
				end
			end
			default: res_next = '0;
		endcase
	end

	out_item_t out_s3;

	always_ff @(posedge clk) begin
		if (ready3)
			out_s3 <= res_next;
	end

	assign out_valid = v_s3;
	assign out_data  = out_s3;

	// a stalled input means every slot is taken and the output is held
	`PQPE_ASSERT_NOW(a_stall_full, clk, arst_n, in_stall,
		v_s1 && v_s2 && v_s3 && out_stall, "input stalled with a free stage")
	// a bad pair gives no rebuilt bytes
	`PQPE_ASSERT_NOW(a_err_zero, clk, arst_n, out_valid && out_data.setup_error,
		(out_data.rebuilt_first == 8'd0) && (out_data.rebuilt_second == 8'd0) &&
		(out_data.parity_p == 8'd0) && (out_data.parity_q == 8'd0),
		"setup error with non-zero result")
	// parity and rebuilt fields never appear together
	`PQPE_ASSERT_NOW(a_parity_excl, clk, arst_n,
		out_valid && ((out_data.parity_p != 8'd0) || (out_data.parity_q != 8'd0)),
		(out_data.rebuilt_first == 8'd0) && (out_data.rebuilt_second == 8'd0) &&
		!out_data.setup_error, "parity mixed with rebuild output")
	// a middle stage that cannot move keeps its contents
	`PQPE_ASSERT_NEXT(a_s2_hold, clk, arst_n, v_s2 && !ready2,
		v_s2 && $stable(t_s2) && $stable(pp_s2), "stalled stage 2 changed")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import pqpe_pkg::*;

	localparam logic [7:0] POLY_LOW     = 8'h1B;
	localparam int         DRAIN_CYCLES = 8;
	localparam int         RANDOM_PHASES = 9;

	typedef logic [0:LANES-1][7:0] lane_bytes_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// register copy, starts at the reset values
	logic [1:0] cur_mode = MODE_ENCODE;
	logic [2:0] cur_lost_a = 3'd0;
	logic [2:0] cur_lost_b = 3'd1;

	in_item_t  columns_to_send[$];
	in_item_t  directed_cols[$];
	out_item_t outcomes_due[$];

	int fail_count = 0;
	int mode_hits[4] = '{0, 0, 0, 0};
	int flagged_results = 0;
	int reg_writes = 0;
	int phase_count = 0;

	int   gap_left = 0;
	int   stall_left = 0;
	int   calm_left = 0;
	logic steady = 1'b0;

	always #5 clk = ~clk;

	pq_parity_erasure_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// gf(2^8) product, msb-first shift and add
	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = 8'd0;
		for (int i = 7; i >= 0; i--) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ POLY_LOW) : {r[6:0], 1'b0};
			if (b[i])
				r = r ^ a;
		end
		return r;
	endfunction

	// inverse by exhaustive search, zero maps to zero
	function automatic logic [7:0] gf_recip(input logic [7:0] x);
		logic [7:0] r;
		r = 8'd0;
		for (int k = 1; k < 256; k++)
			if (gf_times(x, 8'(k)) == 8'd1)
				r = 8'(k);
		return r;
	endfunction

	// 3^u
	function automatic logic [7:0] lane_weight(input int u);
		logic [7:0] c;
		c = 8'd1;
		for (int i = 0; i < u; i++)
			c = gf_times(c, 8'h03);
		return c;
	endfunction

	function automatic lane_bytes_t lanes_of(input in_item_t c);
		return {c.data_0, c.data_1, c.data_2, c.data_3,
			c.data_4, c.data_5, c.data_6, c.data_7};
	endfunction

	// skip[u] leaves lane u out of the sum
	function automatic logic [7:0] xor_sum(input lane_bytes_t d, input logic [LANES-1:0] skip);
		logic [7:0] acc;
		acc = 8'd0;
		for (int u = 0; u < LANES; u++)
			if (!skip[u])
				acc = acc ^ d[u];
		return acc;
	endfunction

	function automatic logic [7:0] weighted_sum(input lane_bytes_t d,
			input logic [LANES-1:0] skip);
		logic [7:0] acc;
		acc = 8'd0;
		for (int u = 0; u < LANES; u++)
			if (!skip[u])
				acc = acc ^ gf_times(lane_weight(u), d[u]);
		return acc;
	endfunction

	// expected result of one column under the current register copy
	function automatic out_item_t predict_column(input in_item_t col);
		lane_bytes_t      d;
		out_item_t        r;
		logic [LANES-1:0] skip;
		logic [7:0]       pp, qq, ca, cb, da;
		d = lanes_of(col);
		r = '0;
		case (cur_mode)
			MODE_ENCODE: begin
				r.parity_p = xor_sum(d, '0);
				r.parity_q = weighted_sum(d, '0);
			end
			MODE_ONE: begin
				r.rebuilt_first = col.p_in ^ xor_sum(d, LANES'(1) << cur_lost_a);
			end
			MODE_TWO: begin
				if (cur_lost_a == cur_lost_b) begin
					r.setup_error = 1'b1;
				end else begin
					skip = (LANES'(1) << cur_lost_a) | (LANES'(1) << cur_lost_b);
					pp = col.p_in ^ xor_sum(d, skip);
					qq = col.q_in ^ weighted_sum(d, skip);
					ca = lane_weight(int'(cur_lost_a));
					cb = lane_weight(int'(cur_lost_b));
					da = gf_times(qq ^ gf_times(cb, pp), gf_recip(ca ^ cb));
					r.rebuilt_first = da;
					r.rebuilt_second = pp ^ da;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// biased towards the byte extremes
	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'h00;
		else if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic in_item_t col_of(input lane_bytes_t d, input logic [7:0] p,
			input logic [7:0] q);
		in_item_t c;
		c = {d, p, q};
		return c;
	endfunction

	// mostly a consistent stripe with garbage in the lost lanes, sometimes pure noise
	function automatic in_item_t make_column(input logic [1:0] m, input logic [2:0] la,
			input logic [2:0] lb);
		lane_bytes_t d;
		logic [7:0]  p, q;
		for (int u = 0; u < LANES; u++)
			d[u] = rand_byte();
		p = xor_sum(d, '0);
		q = weighted_sum(d, '0);
		if (m != MODE_ENCODE && $urandom_range(0, 3) != 0) begin
			d[la] = rand_byte();
			if (m == MODE_TWO)
				d[lb] = rand_byte();
		end else begin
			p = rand_byte();
			q = rand_byte();
		end
		return col_of(d, p, q);
	endfunction

	// mostly short gaps, a few long ones, none at all in a steady stretch
	function automatic int idle_len(input logic quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic note_failure(input string what, input out_item_t want,
			input out_item_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t %s: want p=%02h q=%02h r1=%02h r2=%02h err=%0b, got p=%02h q=%02h r1=%02h r2=%02h err=%0b",
				$realtime, what, want.parity_p, want.parity_q, want.rebuilt_first,
				want.rebuilt_second, want.setup_error, got.parity_p, got.parity_q,
				got.rebuilt_first, got.rebuilt_second, got.setup_error);
	endtask

	// toggles stretches where neither side idles
	always @(posedge clk) begin
		if (calm_left == 0) begin
			calm_left <= $urandom_range(30, 300);
			steady <= ($urandom_range(0, 3) == 0);
		end else begin
			calm_left <= calm_left - 1;
		end
	end

	// column driver: predicts at each input transfer, holds the payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				outcomes_due.push_back(predict_column(in_data));
				mode_hits[cur_mode]++;
			end
			if (in_valid && in_stall) begin
				// hold until the transfer happens
			end else if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (columns_to_send.size() != 0) begin
				in_data <= columns_to_send.pop_front();
				in_valid <= 1'b1;
				gap_left <= idle_len(steady);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor: checks each output transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (outcomes_due.size() == 0) begin
					note_failure("result with nothing outstanding", '0, out_data);
				end else begin
					want = outcomes_due.pop_front();
					if (want.setup_error)
						flagged_results++;
					if (out_data.parity_p !== want.parity_p ||
							out_data.parity_q !== want.parity_q ||
							out_data.rebuilt_first !== want.rebuilt_first ||
							out_data.rebuilt_second !== want.rebuilt_second ||
							out_data.setup_error !== want.setup_error)
						note_failure("result mismatch", want, out_data);
				end
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= idle_len(steady);
			end
		end
	end

	// one config transfer; caller sits on a rising edge, returns on the accepting edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		reg_writes++;
		case (idx)
			REG_MODE:        cur_mode = val[1:0];
			REG_LOST_FIRST:  cur_lost_a = val;
			REG_LOST_SECOND: cur_lost_b = val;
			default: ;
		endcase
	endtask

	// program (optionally), stream directed then random columns, drain
	task automatic run_phase(input logic [1:0] m, input logic [2:0] la, input logic [2:0] lb,
			input logic program_regs, input int n_rand);
		logic top_bit;
		top_bit = 1'($urandom_range(0, 1));
		if (program_regs) begin
			// top data bit is outside the mode field
			write_reg(REG_MODE, {top_bit, m});
			write_reg(REG_LOST_FIRST, la);
			write_reg(REG_LOST_SECOND, lb);
			cfg_valid <= 1'b0;
		end
		phase_count++;
		while (directed_cols.size() != 0)
			columns_to_send.push_back(directed_cols.pop_front());
		for (int k = 0; k < n_rand; k++)
			columns_to_send.push_back(make_column(m, la, lb));
		while (columns_to_send.size() != 0 || in_valid || outcomes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		lane_bytes_t d;
		logic [1:0]  m;
		logic [2:0]  la, lb;
		int          r;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// encode at reset values: zeros, all ones, top bit on the heaviest lane, alternating
		directed_cols.push_back(col_of('0, 8'h00, 8'h00));
		directed_cols.push_back(col_of({LANES{8'hFF}}, 8'hFF, 8'hFF));
		d = '0;
		d[LANES-1] = 8'h80;
		directed_cols.push_back(col_of(d, 8'h00, 8'h00));
		directed_cols.push_back(col_of({4{8'h55, 8'hAA}}, 8'h00, 8'hFF));
		run_phase(MODE_ENCODE, 3'd0, 3'd1, 1'b0, 40);

		// single rebuild of the lowest lane
		directed_cols.push_back(col_of({LANES{8'hFF}}, 8'h00, 8'h00));
		directed_cols.push_back(col_of('0, 8'hFF, 8'hFF));
		run_phase(MODE_ONE, 3'd0, 3'd5, 1'b1, 60);

		// single rebuild of the top lane, second index equal and unused
		directed_cols.push_back(col_of({LANES{8'h80}}, 8'h80, 8'h00));
		run_phase(MODE_ONE, 3'd7, 3'd7, 1'b1, 60);

		// double rebuild at the index extremes, both orders
		directed_cols.push_back(make_column(MODE_TWO, 3'd0, 3'd7));
		directed_cols.push_back(make_column(MODE_TWO, 3'd0, 3'd7));
		directed_cols.push_back(col_of({LANES{8'hFF}}, 8'h00, 8'h00));
		run_phase(MODE_TWO, 3'd0, 3'd7, 1'b1, 70);
		directed_cols.push_back(col_of({LANES{8'hFF}}, 8'hFF, 8'hFF));
		run_phase(MODE_TWO, 3'd7, 3'd0, 1'b1, 70);

		// same unit named twice
		directed_cols.push_back(col_of({LANES{8'hFF}}, 8'hFF, 8'hFF));
		directed_cols.push_back(col_of('0, 8'h00, 8'h00));
		run_phase(MODE_TWO, 3'd3, 3'd3, 1'b1, 30);

		// unused mode value gives all zeros
		directed_cols.push_back(col_of({LANES{8'hFF}}, 8'hFF, 8'hFF));
		directed_cols.push_back(make_column(MODE_TWO, 3'd5, 3'd2));
		run_phase(2'd3, 3'd5, 3'd2, 1'b1, 30);

		run_phase(MODE_ENCODE, 3'd7, 3'd7, 1'b1, 60);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			r = $urandom_range(0, 9);
			if (r < 3)
				m = MODE_ENCODE;
			else if (r < 6)
				m = MODE_ONE;
			else if (r < 9)
				m = MODE_TWO;
			else
				m = 2'd3;
			la = 3'($urandom_range(0, 7));
			lb = ($urandom_range(0, 7) == 0) ? la : 3'($urandom_range(0, 7));
			run_phase(m, la, lb, 1'b1, $urandom_range(30, 90));
		end

		if (outcomes_due.size() != 0) begin
			fail_count += outcomes_due.size();
			$display("%0d predicted results never arrived", outcomes_due.size());
		end

		$display("columns sent: %0d encode, %0d one-unit rebuild, %0d two-unit rebuild, %0d unused mode",
			mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		$display("%0d register writes over %0d phases, %0d results with setup error set",
			reg_writes, phase_count, flagged_results);
		if (fail_count == 0)
			$display("pq_parity_erasure_engine_top verification clean");
		else
			$display("pq_parity_erasure_engine_top verification failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("pq_parity_erasure_engine_top verification failed");
		$finish;
	end

endmodule
